// ===== rtl/ax923_pkg.sv =====
// Package for the ANSI X.923 padding block: sizes, register indexes, status
// codes and the command/status structs between the controller and datapath.
// No dependencies.
package ax923_pkg;

    // Largest supported cipher block in bytes and the widths that follow.
    localparam int MAX_BLOCK  = 32;
    localparam int PTR_W      = $clog2(MAX_BLOCK);
    localparam int CNT_W      = PTR_W + 1;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int USER_W     = 3;

    localparam logic [CNT_W-1:0]  BS_RESET = CNT_W'(16);
    localparam logic [CNT_W-1:0]  BS_MAX   = CNT_W'(MAX_BLOCK);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 2'd1;

    // Direction values.
    localparam logic DIR_ADD   = 1'b0;
    localparam logic DIR_STRIP = 1'b1;

    // Result status reported on the final transfer of a message.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEN  = 2'd1,
        ST_BAD_PAD  = 2'd2,
        ST_BAD_FILL = 2'd3
    } status_t;

    // How the buffer index register moves; the read address follows it.
    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_LAST,
        IDX_FILL,
        IDX_INC
    } idx_op_t;

    // Source of the next output transfer.
    typedef enum logic [2:0] {
        OSEL_IN,
        OSEL_SHIFT,
        OSEL_PAD,
        OSEL_REL,
        OSEL_STATUS
    } out_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     accept;
        logic     cfg_we;
        logic     rd_en;
        idx_op_t  idx_op;
        logic     emit;
        out_sel_t out_sel;
        logic     rp_inc;
        logic     cnt_dec;
        logic     pad_load;
        logic     st_load;
        status_t  st_code;
        logic     clear;
    } ax_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic dir;
        logic in_has;
        logic in_eom;
        logic held_full;
        logic item_eom;
        logic out_free;
        logic cnt_last;
        logic len_bad;
        logic pad_bad;
        logic pad_one;
        logic bs_one;
        logic rdata_nz;
        logic fill_more;
        logic keep_zero;
        logic rel_last;
    } ax_stat_t;

endpackage

// ===== rtl/ax923_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// A read and a write at the same address in one cycle return the old data.
// No dependencies.
module ax923_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ax923_dp.sv =====
// Datapath of the ANSI X.923 padding block: configuration registers, block
// counters, the hold buffer RAM, status checks and the output register.
// Depends on ax923_pkg and ax923_ram.
module ax923_dp import ax923_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [BYTE_W-1:0]     s_tdata,
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  ax_cmd_t               cmd,
    output ax_stat_t              stat,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [BYTE_W-1:0]     m_tdata,
    output logic [USER_W-1:0]     m_tuser,
    output logic                  m_tlast
);

    logic [CNT_W-1:0]  bs_reg;
    logic              dir_reg;
    logic [CNT_W-1:0]  held_reg;
    logic [PTR_W-1:0]  rp_reg;
    logic [PTR_W-1:0]  pos_reg;
    logic              seen_reg;
    logic              item_eom_reg;
    logic [PTR_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  pad_reg;
    logic [CNT_W-1:0]  cnt_reg;
    status_t           st_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_data_reg;
    logic [USER_W-1:0] out_user_reg;
    logic              out_last_reg;

    logic [CNT_W-1:0]  bs_eff;
    logic [CNT_W-1:0]  pos_inc;
    logic [PTR_W-1:0]  pos_next;
    logic [CNT_W-1:0]  add_pad;
    logic              full;
    logic              ram_we;
    logic [PTR_W-1:0]  waddr;
    logic [PTR_W-1:0]  idx_next;
    logic [PTR_W-1:0]  raddr;
    logic [BYTE_W-1:0] rdata;
    logic [CNT_W-1:0]  rp_inc;
    logic              cfg_hit;
    logic              clear_all;
    logic              out_free;
    logic              cnt_last;
    logic              rel_last;
    logic [CNT_W-1:0]  keep;
    logic [BYTE_W-1:0] emit_data;
    logic              emit_valid;
    logic              emit_last;
    status_t           emit_st;

    // Add two ring offsets below the block size and wrap once.
    function automatic logic [PTR_W-1:0] wrap_add(
        input logic [PTR_W-1:0] a,
        input logic [PTR_W-1:0] b,
        input logic [CNT_W-1:0] bs
    );
        logic [CNT_W-1:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= bs) begin
            sum = sum - bs;
        end
        return sum[PTR_W-1:0];
    endfunction

    // Effective block size: zero acts as one, oversize values clamp.
    always_comb begin
        if (bs_reg == '0) begin
            bs_eff = CNT_W'(1);
        end else if (bs_reg > BS_MAX) begin
            bs_eff = BS_MAX;
        end else begin
            bs_eff = bs_reg;
        end
    end

    // Block position after the incoming item and the pad length it implies.
    assign pos_inc  = {1'b0, pos_reg} + CNT_W'(1);
    assign pos_next = !s_tuser ? pos_reg :
                      (pos_inc == bs_eff) ? '0 : pos_inc[PTR_W-1:0];
    assign add_pad  = bs_eff - {1'b0, pos_next};

    // Hold buffer write: overwrite the oldest byte once the buffer is full.
    assign full   = (held_reg >= bs_eff);
    assign ram_we = cmd.accept && (dir_reg == DIR_STRIP) && s_tuser;
    assign waddr  = full ? rp_reg : wrap_add(rp_reg, held_reg[PTR_W-1:0], bs_eff);

    // Index of the next buffer read, relative to the oldest held byte.
    always_comb begin
        case (cmd.idx_op)
            IDX_HOLD: idx_next = idx_reg;
            IDX_ZERO: idx_next = '0;
            IDX_LAST: idx_next = PTR_W'(bs_eff - CNT_W'(1));
            IDX_FILL: idx_next = PTR_W'(bs_eff - rdata[CNT_W-1:0]);
            IDX_INC:  idx_next = idx_reg + PTR_W'(1);
            default:  idx_next = idx_reg;
        endcase
    end

    assign raddr = wrap_add(rp_reg, idx_next, bs_eff);

    ax923_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_BLOCK)
    ) u_hold (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (s_tdata),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rp_inc = {1'b0, rp_reg} + CNT_W'(1);

    // A write to a listed register abandons the message in progress.
    assign cfg_hit   = (cfg_index == REG_BLOCK_SIZE) || (cfg_index == REG_DIRECTION);
    assign clear_all = cmd.clear || (cmd.cfg_we && cfg_hit);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bs_reg  <= BS_RESET;
            dir_reg <= DIR_ADD;
        end else if (cmd.cfg_we) begin
            case (cfg_index)
                REG_BLOCK_SIZE: bs_reg  <= cfg_data;
                REG_DIRECTION:  dir_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Message counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
            rp_reg   <= '0;
            pos_reg  <= '0;
            seen_reg <= 1'b0;
        end else if (clear_all) begin
            held_reg <= '0;
            rp_reg   <= '0;
            pos_reg  <= '0;
            seen_reg <= 1'b0;
        end else begin
            if (cmd.accept) begin
                pos_reg <= pos_next;
                if (s_tuser) begin
                    seen_reg <= 1'b1;
                end
                if (ram_we && !full) begin
                    held_reg <= held_reg + CNT_W'(1);
                end
            end
            if (cmd.rp_inc) begin
                rp_reg <= (rp_inc == bs_eff) ? '0 : rp_inc[PTR_W-1:0];
            end
        end
    end

    // Per-message working registers.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_eom_reg <= s_tlast;
            if (dir_reg == DIR_ADD) begin
                cnt_reg <= add_pad;
                pad_reg <= add_pad;
            end
        end
        if (cmd.cnt_dec) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        if (cmd.pad_load) begin
            pad_reg <= rdata[CNT_W-1:0];
        end
        if (cmd.st_load) begin
            st_reg <= cmd.st_code;
        end
        idx_reg <= idx_next;
    end

    assign cnt_last = (cnt_reg == CNT_W'(1));
    assign keep     = bs_eff - pad_reg;
    assign rel_last = ({1'b0, idx_reg} + CNT_W'(1)) == keep;

    // Output transfer contents by source.
    always_comb begin
        emit_data  = '0;
        emit_valid = 1'b1;
        emit_last  = 1'b0;
        emit_st    = ST_OK;
        case (cmd.out_sel)
            OSEL_IN:    emit_data = s_tdata;
            OSEL_SHIFT: emit_data = rdata;
            OSEL_PAD: begin
                emit_data = cnt_last ? BYTE_W'(pad_reg) : '0;
                emit_last = cnt_last;
            end
            OSEL_REL: begin
                emit_data = rdata;
                emit_last = rel_last;
            end
            OSEL_STATUS: begin
                emit_valid = 1'b0;
                emit_last  = 1'b1;
                emit_st    = st_reg;
            end
            default: ;
        endcase
    end

    // Output register: loads when empty or being drained.
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_data_reg <= emit_data;
            out_user_reg <= {emit_st, emit_valid};
            out_last_reg <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // Status toward the controller.
    always_comb begin
        stat.dir       = dir_reg;
        stat.in_has    = s_tuser;
        stat.in_eom    = s_tlast;
        stat.held_full = full;
        stat.item_eom  = item_eom_reg;
        stat.out_free  = out_free;
        stat.cnt_last  = cnt_last;
        stat.len_bad   = !seen_reg || (pos_reg != '0) || (held_reg != bs_eff);
        stat.pad_bad   = (rdata == '0) || (rdata > BYTE_W'(bs_eff));
        stat.pad_one   = (rdata == BYTE_W'(1));
        stat.bs_one    = (bs_eff == CNT_W'(1));
        stat.rdata_nz  = (rdata != '0);
        stat.fill_more = ({1'b0, idx_reg} + CNT_W'(2)) < bs_eff;
        stat.keep_zero = (pad_reg == bs_eff);
        stat.rel_last  = rel_last;
    end

endmodule

// ===== rtl/ax923_ctrl.sv =====
// Controller of the ANSI X.923 padding block: sequences item intake, pad
// emission and the end-of-message check and release.
// Depends on ax923_pkg.
module ax923_ctrl import ax923_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  ax_stat_t stat,
    output ax_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_SHIFT,
        S_CHK,
        S_PADCHK,
        S_FILL,
        S_REL,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   idle;
    logic   accept;

    assign idle      = (state_reg == S_IDLE);
    assign cfg_ready = idle;
    assign s_tready  = idle && stat.out_free && !cfg_valid;
    assign accept    = s_tvalid && s_tready;

    // Next state and commands.
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.idx_op   = IDX_HOLD;
        cmd.out_sel  = OSEL_IN;
        cmd.st_code  = ST_OK;
        cmd.cfg_we   = cfg_valid && cfg_ready;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.accept = 1'b1;
                    if (stat.dir == DIR_ADD) begin
                        if (stat.in_has) begin
                            cmd.emit    = 1'b1;
                            cmd.out_sel = OSEL_IN;
                        end
                        if (stat.in_eom) begin
                            state_next = S_PAD;
                        end
                    end else if (stat.in_has && stat.held_full) begin
                        // Read the oldest byte while the new one replaces it.
                        cmd.rd_en  = 1'b1;
                        cmd.idx_op = IDX_ZERO;
                        state_next = S_SHIFT;
                    end else if (stat.in_eom) begin
                        state_next = S_CHK;
                    end
                end
            end
            S_PAD: begin
                if (stat.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.out_sel = OSEL_PAD;
                    cmd.cnt_dec = 1'b1;
                    if (stat.cnt_last) begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_SHIFT: begin
                if (stat.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.out_sel = OSEL_SHIFT;
                    cmd.rp_inc  = 1'b1;
                    state_next  = stat.item_eom ? S_CHK : S_IDLE;
                end
            end
            S_CHK: begin
                if (stat.len_bad) begin
                    cmd.st_load = 1'b1;
                    cmd.st_code = ST_BAD_LEN;
                    state_next  = S_FIN;
                end else begin
                    // Fetch the pad length byte at the end of the block.
                    cmd.rd_en  = 1'b1;
                    cmd.idx_op = IDX_LAST;
                    state_next = S_PADCHK;
                end
            end
            S_PADCHK: begin
                cmd.pad_load = 1'b1;
                if (stat.pad_bad) begin
                    cmd.st_load = 1'b1;
                    cmd.st_code = ST_BAD_PAD;
                    state_next  = S_FIN;
                end else if (stat.pad_one) begin
                    if (stat.bs_one) begin
                        cmd.st_load = 1'b1;
                        cmd.st_code = ST_OK;
                        state_next  = S_FIN;
                    end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.idx_op = IDX_ZERO;
                        state_next = S_REL;
                    end
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.idx_op = IDX_FILL;
                    state_next = S_FILL;
                end
            end
            S_FILL: begin
                // Walk the filler bytes, one read per cycle.
                if (stat.rdata_nz) begin
                    cmd.st_load = 1'b1;
                    cmd.st_code = ST_BAD_FILL;
                    state_next  = S_FIN;
                end else if (stat.fill_more) begin
                    cmd.rd_en  = 1'b1;
                    cmd.idx_op = IDX_INC;
                end else if (stat.keep_zero) begin
                    cmd.st_load = 1'b1;
                    cmd.st_code = ST_OK;
                    state_next  = S_FIN;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.idx_op = IDX_ZERO;
                    state_next = S_REL;
                end
            end
            S_REL: begin
                if (stat.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.out_sel = OSEL_REL;
                    if (stat.rel_last) begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.idx_op = IDX_INC;
                    end
                end
            end
            S_FIN: begin
                if (stat.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.out_sel = OSEL_STATUS;
                    cmd.clear   = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/ansi_x923_padding.sv =====
// Top level of the ANSI X.923 padding block: a streaming byte engine that
// adds padding or checks and removes it, as set by the direction register.
// Depends on ax923_pkg, ax923_ctrl and ax923_dp.
//
// Usage:
//   The s_ channel takes one item per transfer: a message byte in s_tdata,
//   s_tuser high when that byte is present, s_tlast high at message end.
//   The m_ channel returns bytes in m_tdata, m_tuser[0] high when the byte
//   is real, m_tuser[2:1] the status, m_tlast on the last transfer of a
//   message. The cfg_ channel writes the block length (index 0) and the
//   direction (index 1) while the block is idle; either write drops the message.
//   Adding: one item per cycle while the output register is free; at message
//   end the pad bytes follow at one per cycle as it frees, up to one full block
//   of them. Removing: a byte that only fills the hold buffer is stored; one
//   that pushes an older byte out sends it on after a registered buffer read.
//   The end check tests the length and the pad length byte, then the filler
//   bytes; the release sends the kept bytes or the status transfer. The add
//   path output is registered and shows in the cycle after acceptance. Reset
//   clears the counters, sets a 16-byte block and direction add. A stalled
//   receiver holds the output register; intake pauses until it is free.
module ansi_x923_padding import ax923_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,  // [7:0] data_byte
    input  logic                  s_tuser,  // [0] has_byte
    input  logic                  s_tlast,
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [BYTE_W-1:0]     m_tdata,  // [7:0] out_byte
    output logic [USER_W-1:0]     m_tuser,  // [0] out_valid, [2:1] status
    output logic                  m_tlast,
    // Configuration writes.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ax_cmd_t  cmd;
    ax_stat_t stat;

    ax923_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ax923_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
